FILE: hw/rtl/rstp_pkg.sv
// Shared types and constants for the row-scan touch position tracker.
package rstp_pkg;

    // Width of one scanned row on the input stream.
    localparam int ROW_BITS_W = 32;
    // Width of a position index.
    localparam int POS_W = 5;
    // Stream data width: the position padded to a whole byte.
    localparam int TDATA_W = 8;

    // Tracker modes; the unused encoding behaves as idle.
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_TRACK    = 2'd1,
        MODE_RELEASED = 2'd2
    } mode_t;

    // What the encoder reports for one row.
    typedef struct packed {
        logic             empty;
        logic [POS_W-1:0] position;
    } row_info_t;

    // What the tracker shows.
    typedef struct packed {
        logic             point_valid;
        logic [POS_W-1:0] position;
    } shown_t;

endpackage

FILE: hw/rtl/rstp_encode.sv
// Priority encoders for one row: emptiness and mean of first and last set index.
module rstp_encode (
    input  logic [rstp_pkg::ROW_BITS_W-1:0] row,
    output rstp_pkg::row_info_t             info
);
    import rstp_pkg::*;

    logic [POS_W-1:0] first_idx;
    logic [POS_W-1:0] last_idx;
    logic [POS_W:0]   idx_sum;

    // Lowest set bit: scan from the top so the lowest hit wins.
    always_comb
    begin
        first_idx = '0;
        for (int i = ROW_BITS_W - 1; i >= 0; i--)
        begin
            if (row[i])
            begin
                first_idx = POS_W'(i);
            end
        end
    end

    // Highest set bit: scan from the bottom so the highest hit wins.
    always_comb
    begin
        last_idx = '0;
        for (int i = 0; i < ROW_BITS_W; i++)
        begin
            if (row[i])
            begin
                last_idx = POS_W'(i);
            end
        end
    end

    // Truncated mean; an empty row gives zero since both indexes are zero.
    assign idx_sum       = {1'b0, first_idx} + {1'b0, last_idx};
    assign info.position = idx_sum[POS_W:1];
    assign info.empty    = (row == '0);

endmodule

FILE: hw/rtl/rstp_fsm.sv
// Tracking state machine: mode, previous-row emptiness, held and shown position.
module rstp_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  rstp_pkg::row_info_t info,
    output rstp_pkg::shown_t    shown_next
);
    import rstp_pkg::*;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic             prev_empty_reg;
    logic [POS_W-1:0] held_pos_reg;
    logic [POS_W-1:0] held_pos_next;
    shown_t           shown_reg;

    // Next mode.
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_TRACK:
            begin
                if (info.empty && !prev_empty_reg)
                begin
                    mode_next = MODE_RELEASED;
                end
            end
            MODE_RELEASED:
            begin
                if (info.empty && prev_empty_reg)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                if (!info.empty && prev_empty_reg)
                begin
                    mode_next = MODE_TRACK;
                end
            end
        endcase
    end

    // Held and shown position for this row.
    always_comb
    begin
        held_pos_next = held_pos_reg;
        shown_next    = shown_reg;
        unique case (mode_reg)
            MODE_TRACK:
            begin
                if (!(info.empty && !prev_empty_reg))
                begin
                    held_pos_next          = info.position;
                    shown_next.point_valid = 1'b1;
                    shown_next.position    = info.position;
                end
            end
            MODE_RELEASED:
            begin
                if (info.empty && prev_empty_reg)
                begin
                    shown_next.point_valid = 1'b0;
                    shown_next.position    = '0;
                end
            end
            default:
            begin
                if (!info.empty && prev_empty_reg)
                begin
                    shown_next.point_valid = 1'b1;
                    shown_next.position    = held_pos_reg;
                end
            end
        endcase
    end

    // State registers advance once per row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            prev_empty_reg <= 1'b1;
            held_pos_reg   <= '0;
            shown_reg      <= '0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            prev_empty_reg <= info.empty;
            held_pos_reg   <= held_pos_next;
            shown_reg      <= shown_next;
        end
    end

endmodule

FILE: hw/rtl/row_scan_touch_position_tracker_unit.sv
// Top level of the row-scan touch position tracker.
//
// Takes one scanned sensor row per request and returns one result per row:
// a valid flag and the shown touch position. A row is captured in an input
// register, passes through the priority encoders and the tracking state
// machine, and lands in a result register once that register is free or
// being emptied, so one row can be taken every cycle while the output is not
// blocked. The input register and the result register are the two pipeline
// stages; the input keeps accepting while a finished result waits, and
// stops only when both stages are full and the result is not taken. Only
// the low ROW_WIDTH bits of a row count (at most 32).
module row_scan_touch_position_tracker_unit #(
    parameter int ROW_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] row_bits
    input  logic [rstp_pkg::ROW_BITS_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] position, [7:5] zero
    output logic [rstp_pkg::TDATA_W-1:0]       m_axis_tdata,
    // [0] point_valid
    output logic                               m_axis_tuser
);
    import rstp_pkg::*;

    localparam int EffWidth = (ROW_WIDTH < ROW_BITS_W) ? ROW_WIDTH : ROW_BITS_W;
    localparam logic [ROW_BITS_W-1:0] RowMask =
        ROW_BITS_W'((65'(1) << EffWidth) - 65'(1));

    logic                  in_valid_reg;
    logic [ROW_BITS_W-1:0] in_row_reg;
    logic                  out_valid_reg;
    shown_t                out_shown_reg;
    logic                  advance;
    row_info_t             info;
    shown_t                shown_next;

    // A row moves on when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_row_reg <= s_axis_tdata & RowMask;
        end
    end

    rstp_encode u_encode (
        .row  (in_row_reg),
        .info (info)
    );

    rstp_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .info       (info),
        .shown_next (shown_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_shown_reg.point_valid <= shown_next.point_valid;
            out_shown_reg.position    <= shown_next.point_valid ? shown_next.position : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_shown_reg.point_valid;
    assign m_axis_tdata  = {{(TDATA_W - POS_W){1'b0}}, out_shown_reg.position};

endmodule

FILE: hw/rtl/rstp_checker.sv
// Port-level checks for the tracker, bound to the top level.
module rstp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [rstp_pkg::TDATA_W-1:0]      m_axis_tdata,
    input logic                              m_axis_tuser
);
    import rstp_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // No position is shown without a touch.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("position nonzero while point_valid is low");

    // The input stalls only when both stages are full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // A fresh result follows an accepted request that passed through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching request");

endmodule

bind row_scan_touch_position_tracker_unit rstp_checker u_rstp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb.sv
// Self-checking testbench for the row-scan touch position tracker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rstp_pkg::*;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ROWS   = 900;
    localparam int CYCLE_LIMIT   = 300000;

    // One directed row; when typed is set, res holds the hand-computed result.
    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        bit                    typed;
        shown_t                res;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [31:0] row_bits
    logic [ROW_BITS_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [4:0] position, [7:5] zero
    logic [TDATA_W-1:0]    m_axis_tdata;
    // [0] point_valid
    logic                  m_axis_tuser;

    // Tracker model state, reset values.
    mode_t                 trk_mode       = MODE_IDLE;
    logic                  trk_prev_empty = 1'b1;
    logic [POS_W-1:0]      trk_held       = '0;
    shown_t                trk_shown      = '0;

    // Results still owed by the block, oldest first.
    shown_t                shown_q[$];
    int                    fail_count = 0;
    int                    rows_sent  = 0;
    bit                    tx_idle_on = 1'b1;
    longint                cycle_count = 0;

    row_scan_touch_position_tracker_unit #(
        .ROW_WIDTH(ROW_BITS_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Advance the tracker model by one row and return what it then shows.
    function automatic shown_t track_row(input logic [ROW_BITS_W-1:0] row_bits);
        logic             empty;
        int               first;
        int               last;
        logic [POS_W-1:0] mean;
        shown_t           res;
        empty = (row_bits == '0);
        first = -1;
        last  = 0;
        for (int i = 0; i < ROW_BITS_W; i++)
        begin
            if (row_bits[i])
            begin
                if (first < 0)
                    first = i;
                last = i;
            end
        end
        mean = (first < 0) ? '0 : POS_W'((first + last) / 2);
        case (trk_mode)
            MODE_TRACK:
            begin
                // The first empty row after a touch releases; otherwise follow the touch.
                if (empty && !trk_prev_empty)
                    trk_mode = MODE_RELEASED;
                else
                begin
                    trk_held  = mean;
                    trk_shown = '{point_valid: 1'b1, position: mean};
                end
            end
            MODE_RELEASED:
            begin
                // A second empty row in a row clears the display.
                if (empty && trk_prev_empty)
                begin
                    trk_shown = '0;
                    trk_mode  = MODE_IDLE;
                end
            end
            default:
            begin
                // A new touch after an empty row shows the held position again.
                if (!empty && trk_prev_empty)
                begin
                    trk_shown = '{point_valid: 1'b1, position: trk_held};
                    trk_mode  = MODE_TRACK;
                end
            end
        endcase
        trk_prev_empty = empty;
        res = trk_shown;
        if (!res.point_valid)
            res.position = '0;
        return res;
    endfunction

    // A non-empty row: a single element, a scattered pattern or a contiguous blob.
    function automatic logic [ROW_BITS_W-1:0] touch_row();
        int          start;
        int          len;
        logic [63:0] blob;
        case ($urandom_range(0, 3))
            0: return 32'h1 << $urandom_range(0, ROW_BITS_W - 1);
            1: return $urandom | (32'h1 << $urandom_range(0, ROW_BITS_W - 1));
            default:
            begin
                start = $urandom_range(0, ROW_BITS_W - 1);
                len   = $urandom_range(1, ROW_BITS_W - start);
                blob  = ((64'h1 << len) - 64'h1) << start;
                return blob[ROW_BITS_W-1:0];
            end
        endcase
    endfunction

    // Offer one row after a random gap and log its expected result once taken.
    task automatic send_row(input logic [ROW_BITS_W-1:0] row_bits, input bit typed,
                            input shown_t typed_res);
        int     gap;
        shown_t res;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row_bits;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = track_row(row_bits);
        shown_q.push_back(typed ? typed_res : res);
        rows_sent++;
    endtask

    // Stimulus: reset, directed rows, then random touch strokes and noise.
    initial
    begin : row_source
        directed_row_t directed_rows [DIRECTED_ROWS];
        bit            paused;
        int            pick;
        int            stroke_len;
        directed_rows = '{
            '{32'h0000_0000, 1'b1, '{1'b0, 5'd0}},   // empty after reset
            '{32'h0000_0001, 1'b1, '{1'b1, 5'd0}},   // touch re-shows held position
            '{32'h8000_0001, 1'b1, '{1'b1, 5'd15}},  // both end elements
            '{32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd15}},
            '{32'h8000_0000, 1'b1, '{1'b1, 5'd31}},  // top element only
            '{32'h0000_0000, 1'b1, '{1'b1, 5'd31}},  // release keeps the display
            '{32'h0001_0000, 1'b1, '{1'b1, 5'd31}},  // touch while released is ignored
            '{32'h0000_0000, 1'b1, '{1'b1, 5'd31}},
            '{32'h0000_0000, 1'b1, '{1'b0, 5'd0}},   // second empty row clears
            '{32'h0000_0000, 1'b1, '{1'b0, 5'd0}},
            '{32'h0000_0100, 1'b1, '{1'b1, 5'd31}},
            '{32'h0000_0100, 1'b1, '{1'b1, 5'd8}},
            '{32'hAAAA_AAAA, 1'b1, '{1'b1, 5'd16}},
            '{32'h5555_5555, 1'b1, '{1'b1, 5'd15}},
            '{32'h0000_F000, 1'b1, '{1'b1, 5'd13}},
            '{32'h0000_0000, 1'b1, '{1'b1, 5'd13}},
            '{32'h0000_0000, 1'b1, '{1'b0, 5'd0}},
            '{32'h0000_0006, 1'b1, '{1'b1, 5'd13}},
            '{32'h0000_0006, 1'b1, '{1'b1, 5'd1}},   // mean rounds down
            '{32'h1234_5678, 1'b0, '{1'b0, 5'd0}},
            '{32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd15}},
            '{32'h0000_0000, 1'b1, '{1'b1, 5'd15}},
            '{32'h4000_0000, 1'b1, '{1'b1, 5'd15}},
            '{32'h4000_0000, 1'b1, '{1'b1, 5'd15}},
            '{32'h0000_0000, 1'b1, '{1'b1, 5'd15}}
        };
        paused        = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_row(directed_rows[i].row_bits, directed_rows[i].typed, directed_rows[i].res);

        // Random part: mostly whole strokes, some noise and lone rows.
        while (rows_sent < DIRECTED_ROWS + RANDOM_ROWS)
        begin
            if (rows_sent % 100 < 12)
                tx_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                repeat ($urandom_range(1, 3)) send_row('0, 1'b0, '0);
                stroke_len = $urandom_range(1, 12);
                for (int k = 0; k < stroke_len; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_row('0, 1'b0, '0);
                    else
                        send_row(touch_row(), 1'b0, '0);
                end
                repeat ($urandom_range(1, 3)) send_row('0, 1'b0, '0);
            end
            else if (pick < 9)
            begin
                repeat ($urandom_range(1, 8))
                    send_row(($urandom_range(0, 3) == 0) ? '0 : $urandom, 1'b0, '0);
            end
            else
                send_row(($urandom_range(0, 1) == 0) ? '0 : touch_row(), 1'b0, '0);

            // Once, let the block drain completely before going on.
            if (!paused && rows_sent >= 500)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (shown_q.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
        end

        // Drain and report.
        s_axis_tvalid <= 1'b0;
        while (shown_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("row_scan_touch_position_tracker_unit regression: pass");
        else
            $display("row_scan_touch_position_tracker_unit regression: fail");
        $finish;
    end

    // Result side: compare each taken result, then stall at random or hold off long.
    initial
    begin : result_sink
        int     stall_left;
        int     hold_left;
        int     results_seen;
        bit     rx_idle_on;
        shown_t want;
        stall_left    = 0;
        hold_left     = 0;
        results_seen  = 0;
        rx_idle_on    = 1'b1;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (shown_q.size() == 0)
                begin
                    $error("unexpected result: point_valid %0d position %0d",
                           m_axis_tuser, m_axis_tdata[POS_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = shown_q.pop_front();
                    if (m_axis_tuser !== want.point_valid)
                    begin
                        $error("point_valid: expected %0d, got %0d",
                               want.point_valid, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[POS_W-1:0] !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, m_axis_tdata[POS_W-1:0]);
                        fail_count++;
                    end
                end
                if (results_seen % 100 == 0)
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                if (results_seen == 300 || results_seen == 650)
                    hold_left = 80;
                stall_left = rx_idle_on ? $urandom_range(0, 10) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("row_scan_touch_position_tracker_unit regression: fail");
            $finish;
        end
    end

endmodule
